@@ rtl/core/tlfs_pkg.sv @@
package tlfs_pkg;

  localparam int PrefixBits    = 3;
  localparam int AddrBits      = 6;
  localparam int CmdBits       = 8;
  localparam int PayloadWidth  = 16;
  localparam int DataBitsWidth = 5;
  localparam int MaxDataBits   = 16;

  // Command frame: prefix, command byte, one padding bit.
  localparam int CmdFrameBits  = PrefixBits + CmdBits + 1;
  // Header of a data frame: prefix and RAM address.
  localparam int DataHdrBits   = PrefixBits + AddrBits;
  localparam int HdrCntWidth   = $clog2(CmdFrameBits + 1);

  localparam int InDataWidth   = 32;
  localparam int OutDataWidth  = 8;
  localparam int CfgAddrWidth  = 3;
  localparam int CfgDataWidth  = 32;

  localparam logic [PrefixBits-1:0] CmdPrefixReset  = 3'd4;
  localparam logic [PrefixBits-1:0] DataPrefixReset = 3'd5;

  // Register select bit of paddr (byte offset bits are ignored).
  localparam logic RegCmdPrefix  = 1'b0;
  localparam logic RegDataPrefix = 1'b1;

  // Frame kind as carried on s_tuser.
  localparam logic KindCommand = 1'b0;
  localparam logic KindData    = 1'b1;

  typedef struct packed {
    logic [PrefixBits-1:0] command_prefix;
    logic [PrefixBits-1:0] data_prefix;
  } cfg_t;

endpackage

@@ rtl/core/tlfs_cfg.sv @@
module tlfs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlfs_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [tlfs_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [tlfs_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                pready,
  output tlfs_pkg::cfg_t                      cfg
);
  import tlfs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command_prefix <= CmdPrefixReset;
      cfg.data_prefix    <= DataPrefixReset;
    end else if (wr_en) begin
      if (paddr[2] == RegCmdPrefix) begin
        cfg.command_prefix <= pwdata[PrefixBits-1:0];
      end else begin
        cfg.data_prefix <= pwdata[PrefixBits-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegCmdPrefix) begin
      prdata[PrefixBits-1:0] = cfg.command_prefix;
    end else begin
      prdata[PrefixBits-1:0] = cfg.data_prefix;
    end
  end

endmodule

@@ rtl/core/tlfs_shifter.sv @@
module tlfs_shifter #(
  parameter int MAX_DATA_BITS = tlfs_pkg::MaxDataBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tlfs_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [tlfs_pkg::AddrBits-1:0]        in_ram_address,
  input  logic [tlfs_pkg::PayloadWidth-1:0]    in_payload,
  input  logic [tlfs_pkg::DataBitsWidth-1:0]   in_data_bits,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_bit,
  output logic                                 out_last
);
  import tlfs_pkg::*;

  localparam int PW = $clog2(MAX_DATA_BITS + 1);

  logic                     busy;
  logic [CmdFrameBits-1:0]  hdr;
  logic [HdrCntWidth-1:0]   hleft;
  logic [PW-1:0]            pleft;
  logic [PayloadWidth-1:0]  pay;

  logic                     accept;
  logic                     step;
  logic                     step_bit;
  logic                     step_last;
  logic                     pbit;
  logic [PW-1:0]            pidx;
  logic [31:0]              pidx_wide;
  logic [5:0]               nbits;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  // A bit moves into the output register whenever that register is free or drains.
  assign step     = busy && (!out_valid || out_ready);

  // Clamp the data length to 1..MAX_DATA_BITS.
  always_comb begin
    nbits = {1'b0, in_data_bits};
    if (nbits == 6'd0) begin
      nbits = 6'd1;
    end
    if (nbits > 6'(MAX_DATA_BITS)) begin
      nbits = 6'(MAX_DATA_BITS);
    end
  end

  // Payload bits above the field width go out as zero.
  always_comb begin
    pidx      = pleft - PW'(1);
    pidx_wide = 32'(pidx);
    if (pidx_wide < 32'(PayloadWidth)) begin
      pbit = pay[pidx_wide[3:0]];
    end else begin
      pbit = 1'b0;
    end
  end

  always_comb begin
    if (hleft != '0) begin
      step_bit  = hdr[CmdFrameBits-1];
      step_last = (hleft == HdrCntWidth'(1)) && (pleft == '0);
    end else begin
      step_bit  = pbit;
      step_last = (pleft == PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      hleft     <= '0;
      pleft     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        if (in_kind == KindCommand) begin
          hleft <= HdrCntWidth'(CmdFrameBits);
          pleft <= '0;
        end else begin
          hleft <= HdrCntWidth'(DataHdrBits);
          pleft <= PW'(nbits);
        end
      end else if (step) begin
        if (hleft != '0) begin
          hleft <= hleft - HdrCntWidth'(1);
        end else begin
          pleft <= pleft - PW'(1);
        end
        if (step_last) begin
          busy <= 1'b0;
        end
      end

      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pay <= in_payload;
      if (in_kind == KindCommand) begin
        hdr <= {cfg.command_prefix, in_payload[CmdBits-1:0], 1'b1};
      end else begin
        hdr <= {cfg.data_prefix, in_ram_address, 3'b000};
      end
    end else if (step && (hleft != '0)) begin
      hdr <= {hdr[CmdFrameBits-2:0], 1'b0};
    end
    if (step) begin
      out_bit  <= step_bit;
      out_last <= step_last;
    end
  end

  a_idle_counts_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (hleft == '0) && (pleft == '0))
    else $error("idle serializer has bits left to send");

  a_accept_loads_header: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && ((hleft == HdrCntWidth'(CmdFrameBits)) ||
                        (hleft == HdrCntWidth'(DataHdrBits))))
    else $error("accepted frame did not load a header length");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (step && step_last) |=> !busy && out_valid && out_last)
    else $error("final bit did not close the frame");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pleft) <= 32'(MAX_DATA_BITS))
    else $error("payload bit count above its maximum");

endmodule

@@ rtl/core/three_wire_lcd_frame_serializer_top.sv @@
// Channel   Direction  Signals                       Contents
// s_*       in         s_tvalid/s_tready/s_tdata     one frame request per transfer
// m_*       out        m_tvalid/m_tready/m_tdata     one serial bit per transfer
// apb       in         psel/penable/pwrite/paddr     prefix registers
//
// Within a frame the shifter sends one bit per cycle unless m_tready stalls it.
// After the request transfer it registers the first bit of the frame onto m_tdata.
// A new request is taken once the last bit of the previous frame sits in the output
// register. Reset is synchronous and restores the prefix registers. A stall on m_tready
// holds the shifter; nothing is dropped.
module three_wire_lcd_frame_serializer_top #(
  parameter int MAX_DATA_BITS = tlfs_pkg::MaxDataBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [5:0] ram_address, [21:6] payload, [26:22] data_bits, rest zero
  input  logic [tlfs_pkg::InDataWidth-1:0]    s_tdata,
  // [0] frame kind, 0 command and 1 data
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] serial_bit, rest zero
  output logic [tlfs_pkg::OutDataWidth-1:0]   m_tdata,
  // frame_last
  output logic                                m_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlfs_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [tlfs_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [tlfs_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                pready
);
  import tlfs_pkg::*;

  cfg_t cfg;
  logic serial_bit;

  tlfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlfs_shifter #(
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_shifter (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_kind        (s_tuser),
    .in_ram_address (s_tdata[5:0]),
    .in_payload     (s_tdata[21:6]),
    .in_data_bits   (s_tdata[26:22]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_bit        (serial_bit),
    .out_last       (m_tlast)
  );

  assign m_tdata = {{(OutDataWidth-1){1'b0}}, serial_bit};

endmodule

@@ test/tb.sv @@
module tb;

  typedef struct packed {
    logic        kind;
    logic [5:0]  ram_addr;
    logic [15:0] payload;
    logic [4:0]  data_bits;
  } frame_req_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_last;
  } lcd_bit_t;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 40;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_req_t      frame_req_q[$];
  lcd_bit_t        bit_expect_q[$];
  tlfs_pkg::cfg_t  prefix_cfg;
  int              reqs_issued   = 0;
  int              reqs_taken    = 0;
  int              mismatch_cnt  = 0;
  int              cycle_cnt     = 0;
  int              tx_idle_pct   = 0;
  int              rx_idle_pct   = 0;
  logic            s_taken       = 1'b0;

  three_wire_lcd_frame_serializer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0d] %s: got %0h, want %0h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Expand one frame request into its serial bits, most significant first.
  task automatic predict_frame(input frame_req_t req);
    logic [31:0] frame_bits;
    int          frame_len;
    int          n;
    lcd_bit_t    b;
    if (req.kind == tlfs_pkg::KindCommand) begin
      frame_bits = {20'd0, prefix_cfg.command_prefix, req.payload[7:0], 1'b1};
      frame_len  = tlfs_pkg::CmdFrameBits;
    end else begin
      n = int'(req.data_bits);
      if (n == 0) n = 1;
      if (n > tlfs_pkg::MaxDataBits) n = tlfs_pkg::MaxDataBits;
      frame_bits = ({23'd0, prefix_cfg.data_prefix, req.ram_addr} << n) |
                   (32'(req.payload) & ((32'd1 << n) - 32'd1));
      frame_len  = tlfs_pkg::DataHdrBits + n;
    end
    for (int i = frame_len - 1; i >= 0; i--) begin
      b.serial_bit = frame_bits[i];
      b.frame_last = (i == 0);
      bit_expect_q.push_back(b);
    end
  endtask

  // Request side: a new transfer is offered once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (frame_req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        frame_req_t req;
        req = frame_req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {5'd0, req.data_bits, req.payload, req.ram_addr};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    lcd_bit_t want;
    frame_req_t req;
    s_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        s_taken       = 1'b1;
        req.kind      = s_tuser;
        req.ram_addr  = s_tdata[5:0];
        req.payload   = s_tdata[21:6];
        req.data_bits = s_tdata[26:22];
        predict_frame(req);
        reqs_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (bit_expect_q.size() == 0) begin
          report_mismatch("serial bit with none pending", int'(m_tdata), 0);
        end else begin
          want = bit_expect_q.pop_front();
          if (m_tdata[0] !== want.serial_bit)
            report_mismatch("serial_bit", int'(m_tdata[0]), int'(want.serial_bit));
          if (m_tdata[7:1] !== 7'd0)
            report_mismatch("m_tdata padding", int'(m_tdata[7:1]), 0);
          if (m_tlast !== want.frame_last)
            report_mismatch("frame_last", int'(m_tlast), int'(want.frame_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("three_wire_lcd_frame_serializer_top: mismatch");
      $finish;
    end
  end

  task automatic add_req(input logic kind, input logic [5:0] ram_addr,
                         input logic [15:0] payload, input logic [4:0] data_bits);
    frame_req_t req;
    req.kind      = kind;
    req.ram_addr  = ram_addr;
    req.payload   = payload;
    req.data_bits = data_bits;
    frame_req_q.push_back(req);
    reqs_issued++;
  endtask

  task automatic add_random_reqs(input int count);
    logic [15:0] payload;
    logic [4:0]  data_bits;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(9);
      payload = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom());
      pick = $urandom_range(19);
      if (pick < 16)
        data_bits = 5'(pick + 1);
      else if (pick == 16)
        data_bits = 5'd0;
      else
        data_bits = 5'($urandom_range(31, 17));
      add_req(1'($urandom_range(1)), 6'($urandom_range(63)), payload, data_bits);
    end
  endtask

  task automatic wait_idle();
    while (reqs_taken != reqs_issued || bit_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // Prefix registers change only with no frame in flight.
  task automatic write_prefix(input logic reg_sel, input logic [2:0] value);
    wait_idle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {29'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == tlfs_pkg::RegCmdPrefix)
      prefix_cfg.command_prefix = value;
    else
      prefix_cfg.data_prefix = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [2:0] cmd_pre;
    logic [2:0] data_pre;
    prefix_cfg.command_prefix = tlfs_pkg::CmdPrefixReset;
    prefix_cfg.data_prefix    = tlfs_pkg::DataPrefixReset;
    tx_idle_pct = 11;
    rx_idle_pct = 66;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset prefixes.
    add_req(tlfs_pkg::KindCommand, 6'd0,  16'h0000, 5'd0);
    add_req(tlfs_pkg::KindCommand, 6'd0,  16'hFFFF, 5'd16);
    add_req(tlfs_pkg::KindCommand, 6'd0,  16'hFF5A, 5'd1);
    add_req(tlfs_pkg::KindCommand, 6'd63, 16'h00A5, 5'd31);
    add_req(tlfs_pkg::KindData,    6'd0,  16'h0000, 5'd1);
    add_req(tlfs_pkg::KindData,    6'd63, 16'hFFFF, 5'd16);
    add_req(tlfs_pkg::KindData,    6'h2A, 16'h0001, 5'd0);
    add_req(tlfs_pkg::KindData,    6'h15, 16'hFFFE, 5'd0);
    add_req(tlfs_pkg::KindData,    6'h0F, 16'hA5C3, 5'd17);
    add_req(tlfs_pkg::KindData,    6'd0,  16'hFFFF, 5'd31);
    add_req(tlfs_pkg::KindData,    6'h30, 16'h1234, 5'd8);
    add_req(tlfs_pkg::KindData,    6'h15, 16'hFFE0, 5'd5);
    add_req(tlfs_pkg::KindData,    6'h2A, 16'h8000, 5'd15);
    add_req(tlfs_pkg::KindData,    6'h01, 16'h8001, 5'd16);
    add_req(tlfs_pkg::KindData,    6'h3E, 16'h7FFF, 5'd16);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cmd_pre = 3'd0; data_pre = 3'd7; end
        1: begin cmd_pre = 3'd7; data_pre = 3'd0; end
        3: begin cmd_pre = 3'd7; data_pre = 3'd7; end
        4: begin cmd_pre = 3'd0; data_pre = 3'd0; end
        default: begin
          cmd_pre  = 3'($urandom());
          data_pre = 3'($urandom());
        end
      endcase
      write_prefix(tlfs_pkg::RegCmdPrefix, cmd_pre);
      write_prefix(tlfs_pkg::RegDataPrefix, data_pre);
      if (phase == 2) begin
        tx_idle_pct = 66;
        rx_idle_pct = 11;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      add_random_reqs(45);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("three_wire_lcd_frame_serializer_top: match");
    end else begin
      $display("three_wire_lcd_frame_serializer_top: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tlfs_pkg.sv
rtl/core/tlfs_cfg.sv
rtl/core/tlfs_shifter.sv
rtl/core/three_wire_lcd_frame_serializer_top.sv
test/tb.sv
